[sv/fmq_pkg.sv]
package fmq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PAYLOAD_BYTES = 8;

    localparam int SLOT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int PAY_W    = 8 * PAYLOAD_BYTES;
    localparam int EVENT_W  = 32;
    localparam int LEN_W    = 4;
    localparam int FUNC_W   = 3;
    localparam int QUEUED_W = 5;
    localparam int OUT_PAY_W = 64;

    localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(QUEUE_DEPTH);

    localparam logic [2:0] ADDR_QUIT_EVENT = 3'd0;

    localparam logic [FUNC_W-1:0] FN_SEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POST  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_GET   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_PEEK  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;

    typedef struct packed {
        logic latch;
        logic enq;
        logic link_tail;
        logic clear;
        logic walk_init;
        logic walk_adv;
        logic hit;
        logic unlink_fin;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_enq;
        logic enq_back;
        logic is_search;
        logic is_clear;
        logic free_empty;
        logic tail_valid;
        logic walk_end;
        logic match;
        logic do_remove;
    } t_status;

    function automatic logic is_slot(input logic [SLOT_W-1:0] s);
        return s < NIL_SLOT;
    endfunction

    function automatic logic [LEN_W-1:0] sat_length(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : len;
    endfunction

    function automatic logic [PAY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [PAY_W-1:0] m;
        m = '0;
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            m[8*b +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

[sv/fmq_datapath.sv]
module fmq_datapath import fmq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [EVENT_W-1:0]   i_event_req,
    input  logic [LEN_W-1:0]     i_length,
    input  logic [OUT_PAY_W-1:0] i_payload,
    input  logic [EVENT_W-1:0]   i_filter_min,
    input  logic [EVENT_W-1:0]   i_filter_max,
    input  logic                 i_remove,
    input  logic [EVENT_W-1:0]   i_quit_event,
    output logic                 o_ok,
    output logic [EVENT_W-1:0]   o_out_event,
    output logic [LEN_W-1:0]     o_out_length,
    output logic [OUT_PAY_W-1:0] o_out_payload,
    output logic                 o_is_quit,
    output logic [QUEUED_W-1:0]  o_queued
);

    logic [SLOT_W-1:0]  r_next_link    [QUEUE_DEPTH];
    logic [EVENT_W-1:0] r_slot_event   [QUEUE_DEPTH];
    logic [LEN_W-1:0]   r_slot_length  [QUEUE_DEPTH];
    logic [PAY_W-1:0]   r_slot_payload [QUEUE_DEPTH];

    logic [FUNC_W-1:0]  r_func;
    logic [EVENT_W-1:0] r_ev;
    logic [LEN_W-1:0]   r_len;
    logic [PAY_W-1:0]   r_pay;
    logic [EVENT_W-1:0] r_fmin;
    logic [EVENT_W-1:0] r_fmax;
    logic               r_rem;

    logic [SLOT_W-1:0]  r_head, n_head;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [SLOT_W-1:0]  r_free, n_free;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SLOT_W-1:0]  r_cur, n_cur;
    logic [SLOT_W-1:0]  r_prev, n_prev;
    logic [CNT_W-1:0]   r_steps, n_steps;
    logic [SLOT_W-1:0]  r_aux, n_aux;

    logic               r_p_ok, n_p_ok;
    logic [EVENT_W-1:0] r_p_ev, n_p_ev;
    logic [LEN_W-1:0]   r_p_len, n_p_len;
    logic [PAY_W-1:0]   r_p_pay, n_p_pay;
    logic               r_p_quit, n_p_quit;

    logic               r_o_ok;
    logic [EVENT_W-1:0] r_o_ev;
    logic [LEN_W-1:0]   r_o_len;
    logic [PAY_W-1:0]   r_o_pay;
    logic               r_o_quit;
    logic [CNT_W-1:0]   r_o_count;

    logic [SLOT_W-1:0]  rd_slot;
    logic [SLOT_W-1:0]  rd_link;
    logic [IDX_W-1:0]   cur_idx;
    logic [EVENT_W-1:0] cur_event;
    logic               cur_match;
    logic               do_remove;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [SLOT_W-1:0]  wr_data;
    logic               slot_we;

    assign rd_slot   = i_cmd.enq ? r_free : r_cur;
    assign rd_link   = r_next_link[rd_slot[IDX_W-1:0]];
    assign cur_idx   = r_cur[IDX_W-1:0];
    assign cur_event = r_slot_event[cur_idx];
    assign cur_match = is_slot(r_cur) && (cur_event >= r_fmin)
                       && ((r_fmax == '0) || (cur_event <= r_fmax));
    assign do_remove = (r_func == FN_GET) || r_rem;

    always_comb begin
        o_status.is_enq     = (r_func == FN_SEND) || (r_func == FN_POST);
        o_status.enq_back   = (r_func == FN_POST);
        o_status.is_search  = (r_func == FN_GET) || (r_func == FN_PEEK);
        o_status.is_clear   = (r_func == FN_CLEAR);
        o_status.free_empty = !is_slot(r_free);
        o_status.tail_valid = is_slot(r_tail);
        o_status.walk_end   = !is_slot(r_cur) || (r_steps == CNT_W'(QUEUE_DEPTH));
        o_status.match      = cur_match;
        o_status.do_remove  = do_remove;
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_count  = r_count;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_aux    = r_aux;
        n_p_ok   = r_p_ok;
        n_p_ev   = r_p_ev;
        n_p_len  = r_p_len;
        n_p_pay  = r_p_pay;
        n_p_quit = r_p_quit;
        wr_en    = 1'b0;
        wr_idx   = '0;
        wr_data  = '0;
        slot_we  = 1'b0;

        if (i_cmd.latch) begin
            n_p_ok   = 1'b0;
            n_p_ev   = '0;
            n_p_len  = '0;
            n_p_pay  = '0;
            n_p_quit = 1'b0;
        end

        if (i_cmd.enq && is_slot(r_free)) begin
            slot_we = 1'b1;
            n_free  = rd_link;
            n_aux   = r_free;
            n_count = r_count + 1'b1;
            n_p_ok  = 1'b1;
            wr_en   = 1'b1;
            wr_idx  = r_free[IDX_W-1:0];
            if (r_func == FN_SEND) begin
                wr_data = r_head;
                n_head  = r_free;
                if (!is_slot(r_tail)) begin
                    n_tail = r_free;
                end
            end else begin
                wr_data = NIL_SLOT;
                if (!is_slot(r_tail)) begin
                    n_head = r_free;
                    n_tail = r_free;
                end
            end
        end

        if (i_cmd.link_tail) begin
            wr_en   = 1'b1;
            wr_idx  = r_tail[IDX_W-1:0];
            wr_data = r_aux;
            n_tail  = r_aux;
        end

        if (i_cmd.clear) begin
            n_free  = '0;
            n_head  = NIL_SLOT;
            n_tail  = NIL_SLOT;
            n_count = '0;
            n_p_ok  = 1'b1;
        end

        if (i_cmd.walk_init) begin
            n_cur   = r_head;
            n_prev  = NIL_SLOT;
            n_steps = '0;
        end

        if (i_cmd.walk_adv) begin
            n_prev  = r_cur;
            n_cur   = rd_link;
            n_steps = r_steps + 1'b1;
        end

        if (i_cmd.hit) begin
            n_p_ok   = 1'b1;
            n_p_ev   = cur_event;
            n_p_len  = r_slot_length[cur_idx];
            n_p_pay  = r_slot_payload[cur_idx];
            n_p_quit = (r_func == FN_GET) && (cur_event == i_quit_event);
            if (do_remove) begin
                wr_en   = 1'b1;
                wr_idx  = cur_idx;
                wr_data = r_free;
                n_free  = r_cur;
                n_aux   = rd_link;
                if (r_tail == r_cur) begin
                    n_tail = r_prev;
                end
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
        end

        if (i_cmd.unlink_fin) begin
            if (is_slot(r_prev)) begin
                wr_en   = 1'b1;
                wr_idx  = r_prev[IDX_W-1:0];
                wr_data = r_aux;
            end else begin
                n_head = r_aux;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_next_link[i] <= SLOT_W'(i + 1);
            end
        end else if (wr_en) begin
            r_next_link[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= NIL_SLOT;
            r_tail  <= NIL_SLOT;
            r_free  <= '0;
            r_count <= '0;
            r_cur   <= NIL_SLOT;
            r_prev  <= NIL_SLOT;
            r_steps <= '0;
            r_aux   <= NIL_SLOT;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            r_steps <= n_steps;
            r_aux   <= n_aux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_ev   <= i_event_req;
            r_len  <= sat_length(i_length);
            r_pay  <= i_payload[PAY_W-1:0] & byte_mask(sat_length(i_length));
            r_fmin <= i_filter_min;
            r_fmax <= i_filter_max;
            r_rem  <= i_remove;
        end
        if (slot_we) begin
            r_slot_event[r_free[IDX_W-1:0]]   <= r_ev;
            r_slot_length[r_free[IDX_W-1:0]]  <= r_len;
            r_slot_payload[r_free[IDX_W-1:0]] <= r_pay;
        end
        r_p_ok   <= n_p_ok;
        r_p_ev   <= n_p_ev;
        r_p_len  <= n_p_len;
        r_p_pay  <= n_p_pay;
        r_p_quit <= n_p_quit;
        if (i_cmd.load_out) begin
            r_o_ok    <= r_p_ok;
            r_o_ev    <= r_p_ev;
            r_o_len   <= r_p_len;
            r_o_pay   <= r_p_pay;
            r_o_quit  <= r_p_quit;
            r_o_count <= r_count;
        end
    end

    assign o_ok          = r_o_ok;
    assign o_out_event   = r_o_ev;
    assign o_out_length  = r_o_len;
    assign o_out_payload = OUT_PAY_W'(r_o_pay);
    assign o_is_quit     = r_o_quit;
    assign o_queued      = QUEUED_W'(r_o_count);

endmodule

[sv/fmq_controller.sv]
module fmq_controller import fmq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_LINK   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_UNLINK = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                if (i_status.is_enq) begin
                    o_cmd.enq = 1'b1;
                    if (!i_status.free_empty && i_status.enq_back
                        && i_status.tail_valid) begin
                        n_state = S_LINK;
                    end
                end else if (i_status.is_search) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end else if (i_status.is_clear) begin
                    o_cmd.clear = 1'b1;
                end
            end
            S_LINK: begin
                o_cmd.link_tail = 1'b1;
                n_state         = S_RESP;
            end
            S_WALK: begin
                if (i_status.walk_end) begin
                    n_state = S_RESP;
                end else if (i_status.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = i_status.do_remove ? S_UNLINK : S_RESP;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                end
            end
            S_UNLINK: begin
                o_cmd.unlink_fin = 1'b1;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[sv/filtered_message_queue.sv]
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_func .. i_remove
// out      output     o_out_valid / i_out_stall  o_ok .. o_queued
// config   input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Send, post and clear pass through EXEC and RESP after the beat is latched in IDLE;
// a post onto a non-empty queue adds LINK if a slot is free, as the old tail link
// is a second write. Get and peek walk the linked queue one entry a cycle through
// the slot store in WALK, visiting at most 16 entries; a removed match adds UNLINK.
// Reset restores the free chain in the same cycle; no clearing pass is needed.
// A finished result waits in the output register while the out channel stalls,
// and the next beat is taken meanwhile.
module filtered_message_queue import fmq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [EVENT_W-1:0]   i_event_req,
    input  logic [LEN_W-1:0]     i_length,
    input  logic [OUT_PAY_W-1:0] i_payload,
    input  logic [EVENT_W-1:0]   i_filter_min,
    input  logic [EVENT_W-1:0]   i_filter_max,
    input  logic                 i_remove,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_ok,
    output logic [EVENT_W-1:0]   o_out_event,
    output logic [LEN_W-1:0]     o_out_length,
    output logic [OUT_PAY_W-1:0] o_out_payload,
    output logic                 o_is_quit,
    output logic [QUEUED_W-1:0]  o_queued,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [EVENT_W-1:0] r_quit_event;
    t_cmd               cmd;
    t_status            status;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_QUIT_EVENT) ? r_quit_event : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quit_event <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_QUIT_EVENT)) begin
            r_quit_event <= pwdata;
        end
    end

    fmq_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    fmq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_func        (i_func),
        .i_event_req   (i_event_req),
        .i_length      (i_length),
        .i_payload     (i_payload),
        .i_filter_min  (i_filter_min),
        .i_filter_max  (i_filter_max),
        .i_remove      (i_remove),
        .i_quit_event  (r_quit_event),
        .o_ok          (o_ok),
        .o_out_event   (o_out_event),
        .o_out_length  (o_out_length),
        .o_out_payload (o_out_payload),
        .o_is_quit     (o_is_quit),
        .o_queued      (o_queued)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block took no work after an accepted beat");

    a_quit_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_quit) |-> o_ok)
        else $error("quit flagged on a result without a found message");

    a_fail_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |->
        (o_out_event == '0) && (o_out_length == '0) && (o_out_payload == '0))
        else $error("failed result carries message fields");
`endif

endmodule

[tb/sv/fmq_checker.sv]
`timescale 1ns / 1ps

module fmq_checker import fmq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [EVENT_W-1:0]   i_event_req,
    input  logic [LEN_W-1:0]     i_length,
    input  logic [OUT_PAY_W-1:0] i_payload,
    input  logic [EVENT_W-1:0]   i_filter_min,
    input  logic [EVENT_W-1:0]   i_filter_max,
    input  logic                 i_remove,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_ok,
    input  logic [EVENT_W-1:0]   i_out_event,
    input  logic [LEN_W-1:0]     i_out_length,
    input  logic [OUT_PAY_W-1:0] i_out_payload,
    input  logic                 i_is_quit,
    input  logic [QUEUED_W-1:0]  i_queued,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [2:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    output int                   o_mismatches,
    output int                   o_replies_due
);

    typedef struct packed {
        logic                 ok;
        logic [EVENT_W-1:0]   ev;
        logic [LEN_W-1:0]     len;
        logic [OUT_PAY_W-1:0] pay;
        logic                 quit;
        logic [QUEUED_W-1:0]  queued;
    } t_reply;

    logic [SLOT_W-1:0]  link_of    [QUEUE_DEPTH];
    logic [EVENT_W-1:0] event_of   [QUEUE_DEPTH];
    logic [LEN_W-1:0]   length_of  [QUEUE_DEPTH];
    logic [PAY_W-1:0]   payload_of [QUEUE_DEPTH];
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  tail_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic [CNT_W-1:0]   held;
    logic [EVENT_W-1:0] quit_code;
    t_reply             replies_due [$];

    function automatic void empty_pool();
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            link_of[i] = SLOT_W'(i + 1);
        end
        free_slot = '0;
        head_slot = NIL_SLOT;
        tail_slot = NIL_SLOT;
        held      = '0;
    endfunction

    function automatic t_reply queue_reply(
        input logic [FUNC_W-1:0]    func,
        input logic [EVENT_W-1:0]   ev,
        input logic [LEN_W-1:0]     len,
        input logic [OUT_PAY_W-1:0] pay,
        input logic [EVENT_W-1:0]   fmin,
        input logic [EVENT_W-1:0]   fmax,
        input logic                 rem
    );
        t_reply            r;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] after;
        logic [LEN_W-1:0]  kept;
        logic [PAY_W-1:0]  mask;
        logic              found;
        r = '0;
        case (func) inside
            FN_SEND, FN_POST: begin
                s = free_slot;
                if (s < NIL_SLOT) begin
                    free_slot = link_of[s[IDX_W-1:0]];
                    kept = (len > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : len;
                    mask = '1;
                    if (kept < LEN_W'(PAYLOAD_BYTES)) begin
                        mask = (PAY_W'(1) << (8 * kept)) - PAY_W'(1);
                    end
                    event_of[s[IDX_W-1:0]]   = ev;
                    length_of[s[IDX_W-1:0]]  = kept;
                    payload_of[s[IDX_W-1:0]] = pay & mask;
                    if (func == FN_SEND) begin
                        link_of[s[IDX_W-1:0]] = head_slot;
                        head_slot = s;
                        if (!(tail_slot < NIL_SLOT)) begin
                            tail_slot = s;
                        end
                    end else begin
                        link_of[s[IDX_W-1:0]] = NIL_SLOT;
                        if (tail_slot < NIL_SLOT) begin
                            link_of[tail_slot[IDX_W-1:0]] = s;
                        end else begin
                            head_slot = s;
                        end
                        tail_slot = s;
                    end
                    held = held + 1'b1;
                    r.ok = 1'b1;
                end
            end
            FN_GET, FN_PEEK: begin
                prev  = NIL_SLOT;
                s     = head_slot;
                found = 1'b0;
                for (int k = 0; k < QUEUE_DEPTH; k++) begin
                    if (!found && s < NIL_SLOT) begin
                        if (event_of[s[IDX_W-1:0]] >= fmin &&
                            (fmax == '0 || event_of[s[IDX_W-1:0]] <= fmax)) begin
                            found = 1'b1;
                            r.ok  = 1'b1;
                            r.ev  = event_of[s[IDX_W-1:0]];
                            r.len = length_of[s[IDX_W-1:0]];
                            r.pay = payload_of[s[IDX_W-1:0]];
                            if (func == FN_GET) begin
                                r.quit = (event_of[s[IDX_W-1:0]] == quit_code);
                            end
                            if (func == FN_GET || rem) begin
                                after = link_of[s[IDX_W-1:0]];
                                if (prev < NIL_SLOT) begin
                                    link_of[prev[IDX_W-1:0]] = after;
                                end else begin
                                    head_slot = after;
                                end
                                if (tail_slot == s) begin
                                    tail_slot = prev;
                                end
                                if (held != '0) begin
                                    held = held - 1'b1;
                                end
                                link_of[s[IDX_W-1:0]] = free_slot;
                                free_slot = s;
                            end
                        end else begin
                            prev = s;
                            s    = link_of[s[IDX_W-1:0]];
                        end
                    end
                end
            end
            FN_CLEAR: begin
                empty_pool();
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.queued = QUEUED_W'(held);
        return r;
    endfunction

    function automatic int differs(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            empty_pool();
            quit_code = '0;
            replies_due.delete();
            o_mismatches  <= 0;
            o_replies_due <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_ok, i_out_event, i_out_length, i_out_payload, i_is_quit, i_queued};
                if (replies_due.size() == 0) begin
                    $error("result beat arrived with no request outstanding");
                    errs = 1;
                end else begin
                    want = replies_due.pop_front();
                    errs = differs("ok", 64'(want.ok), 64'(got.ok))
                         + differs("out_event", 64'(want.ev), 64'(got.ev))
                         + differs("out_length", 64'(want.len), 64'(got.len))
                         + differs("out_payload", want.pay, got.pay)
                         + differs("is_quit", 64'(want.quit), 64'(got.quit))
                         + differs("queued", 64'(want.queued), 64'(got.queued));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_QUIT_EVENT) begin
                quit_code = i_pwdata;
            end
            if (i_in_valid && !i_in_stall) begin
                replies_due.push_back(queue_reply(i_func, i_event_req, i_length, i_payload,
                                                  i_filter_min, i_filter_max, i_remove));
            end
            o_mismatches  <= o_mismatches + errs;
            o_replies_due <= replies_due.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top import fmq_pkg::*; ();

    localparam logic [FUNC_W-1:0] FN_SPARE_MIN = FN_CLEAR + 3'd1;
    localparam int                PHASE_ITEMS  = 380;

    typedef struct {
        logic [FUNC_W-1:0]    func;
        logic [EVENT_W-1:0]   ev;
        logic [LEN_W-1:0]     len;
        logic [OUT_PAY_W-1:0] pay;
        logic [EVENT_W-1:0]   fmin;
        logic [EVENT_W-1:0]   fmax;
        logic                 rem;
    } t_request;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func       = '0;
    logic [EVENT_W-1:0]   event_req  = '0;
    logic [LEN_W-1:0]     length     = '0;
    logic [OUT_PAY_W-1:0] payload    = '0;
    logic [EVENT_W-1:0]   filter_min = '0;
    logic [EVENT_W-1:0]   filter_max = '0;
    logic                 remove     = 1'b0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic                 ok;
    logic [EVENT_W-1:0]   out_event;
    logic [LEN_W-1:0]     out_length;
    logic [OUT_PAY_W-1:0] out_payload;
    logic                 is_quit;
    logic [QUEUED_W-1:0]  queued;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [2:0]           paddr      = '0;
    logic [31:0]          pwdata     = '0;
    logic [31:0]          prdata;
    logic                 pready;
    int                   mismatch_n;
    int                   due_n;
    int                   send_gap   = 15;
    int                   recv_gap   = 70;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    filtered_message_queue uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_event_req(event_req), .i_length(length), .i_payload(payload),
        .i_filter_min(filter_min), .i_filter_max(filter_max), .i_remove(remove),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_ok(ok), .o_out_event(out_event), .o_out_length(out_length),
        .o_out_payload(out_payload), .o_is_quit(is_quit), .o_queued(queued),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fmq_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_event_req(event_req), .i_length(length), .i_payload(payload),
        .i_filter_min(filter_min), .i_filter_max(filter_max), .i_remove(remove),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_ok(ok), .i_out_event(out_event), .i_out_length(out_length),
        .i_out_payload(out_payload), .i_is_quit(is_quit), .i_queued(queued),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_mismatches(mismatch_n), .o_replies_due(due_n)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_gap);
    end

    function automatic t_request make_req(
        input logic [FUNC_W-1:0]    f,
        input logic [EVENT_W-1:0]   ev,
        input logic [LEN_W-1:0]     len,
        input logic [OUT_PAY_W-1:0] pay,
        input logic [EVENT_W-1:0]   fmin,
        input logic [EVENT_W-1:0]   fmax,
        input logic                 rem
    );
        t_request r;
        r.func = f;
        r.ev   = ev;
        r.len  = len;
        r.pay  = pay;
        r.fmin = fmin;
        r.fmax = fmax;
        r.rem  = rem;
        return r;
    endfunction

    // Alternating stretches favour filling the pool and draining it, so that both
    // the full pool and the empty queue are reached often.
    function automatic t_request random_req(input logic filling);
        t_request r;
        int       pick;
        int       cut_send;
        int       cut_post;
        int       cut_get;
        int       cut_peek;
        cut_send = filling ? 30 : 12;
        cut_post = filling ? 65 : 25;
        cut_get  = filling ? 80 : 60;
        cut_peek = filling ? 94 : 92;
        pick = $urandom_range(99);
        if (pick < cut_send) begin
            r.func = FN_SEND;
        end else if (pick < cut_post) begin
            r.func = FN_POST;
        end else if (pick < cut_get) begin
            r.func = FN_GET;
        end else if (pick < cut_peek) begin
            r.func = FN_PEEK;
        end else if (pick < 96) begin
            r.func = FN_CLEAR;
        end else begin
            r.func = FN_SPARE_MIN + FUNC_W'($urandom_range(2));
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            r.ev = EVENT_W'($urandom_range(31));
        end else if (pick < 90) begin
            r.ev = $urandom;
        end else if (pick < 95) begin
            r.ev = '0;
        end else begin
            r.ev = '1;
        end
        if ($urandom_range(99) < 75) begin
            r.len = LEN_W'($urandom_range(PAYLOAD_BYTES));
        end else begin
            r.len = LEN_W'($urandom_range(15, PAYLOAD_BYTES + 1));
        end
        r.pay = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 25) begin
            r.fmin = '0;
            r.fmax = '0;
        end else if (pick < 60) begin
            r.fmin = EVENT_W'($urandom_range(31));
            r.fmax = '0;
        end else if (pick < 90) begin
            r.fmin = EVENT_W'($urandom_range(31));
            r.fmax = r.fmin + EVENT_W'($urandom_range(15));
        end else begin
            r.fmin = $urandom;
            r.fmax = $urandom;
        end
        r.rem = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic put_item(input t_request r);
        while ($urandom_range(99) < send_gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func       <= r.func;
        event_req  <= r.ev;
        length     <= r.len;
        payload    <= r.pay;
        filter_min <= r.fmin;
        filter_max <= r.fmax;
        remove     <= r.rem;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic pause_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_n != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++) begin
            put_item(random_req(((i / 40) % 2) == 0));
            if (i == count / 2) begin
                pause_until_idle();
            end
        end
    endtask

    initial begin : stimulus
        logic [EVENT_W-1:0] ev;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        cfg_write(ADDR_QUIT_EVENT, 32'd7);

        // Fill the whole pool with mixed sends and posts, covering the event and
        // length extremes, then try once more each way on the full pool.
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ev = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : (i == 2) ? 32'd7
                                                                        : EVENT_W'(i + 20);
            put_item(make_req((i % 3 == 0) ? FN_SEND : FN_POST, ev, LEN_W'(i),
                              (i % 2 == 0) ? '1 : {$urandom, $urandom},
                              $urandom, $urandom, 1'($urandom_range(1))));
        end
        put_item(make_req(FN_SEND, 32'd99, 4'd8, '1, '0, '0, 1'b0));
        put_item(make_req(FN_POST, 32'd99, 4'd8, '1, '0, '0, 1'b0));
        put_item(make_req(FN_PEEK, '0, '0, '0, 32'd0, 32'd0, 1'b0));
        put_item(make_req(FN_PEEK, '0, '0, '0, 32'd5, 32'd0, 1'b1));
        put_item(make_req(FN_GET, '0, '0, '0, 32'd7, 32'd7, 1'b0));
        put_item(make_req(FN_GET, '0, '0, '0, 32'd8, 32'd0, 1'b0));
        put_item(make_req(FN_GET, '0, '0, '0, 32'd100, 32'd200, 1'b1));
        put_item(make_req(FN_GET, '0, '0, '0, 32'hFFFF_FFFF, 32'd0, 1'b0));
        put_item(make_req(FN_SPARE_MIN + 3'd2, '1, '1, '1, '1, '1, 1'b1));
        put_item(make_req(FN_CLEAR, '0, '0, '0, '0, '0, 1'b0));
        put_item(make_req(FN_GET, '0, '0, '0, 32'd0, 32'd0, 1'b0));

        pause_until_idle();
        cfg_write(ADDR_QUIT_EVENT, 32'hFFFF_FFFF);
        random_run(PHASE_ITEMS);

        pause_until_idle();
        send_gap = 70;
        recv_gap = 15;
        cfg_write(ADDR_QUIT_EVENT, 32'd0);
        random_run(PHASE_ITEMS);

        pause_until_idle();
        send_gap = 0;
        recv_gap = 0;
        cfg_write(ADDR_QUIT_EVENT, 32'($urandom_range(31)));
        random_run(PHASE_ITEMS);

        pause_until_idle();
        repeat (30) @(posedge clk);
        if (mismatch_n == 0 && due_n == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(8_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/fmq_pkg.sv
sv/fmq_datapath.sv
sv/fmq_controller.sv
sv/filtered_message_queue.sv
tb/sv/fmq_checker.sv
tb/sv/tb_top.sv
